@@ sv/mvcc_pkg.sv @@
// Shared types and constants of the MVCC transaction table.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none
package mvcc_pkg;

  localparam logic [2:0] OP_START   = 3'd0;
  localparam logic [2:0] OP_COMMIT  = 3'd1;
  localparam logic [2:0] OP_ABORT   = 3'd2;
  localparam logic [2:0] OP_VISIBLE = 3'd3;
  localparam logic [2:0] OP_CMTQ    = 3'd4;
  localparam logic [2:0] OP_SNAP    = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_SLOT  = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_INACTIVE = 2'd3;

  localparam logic [1:0] PH_FREE      = 2'd0;
  localparam logic [1:0] PH_ACTIVE    = 2'd1;
  localparam logic [1:0] PH_COMMITTED = 2'd2;
  localparam logic [1:0] PH_ABORTED   = 2'd3;

  localparam int unsigned MAX_LIST = 7;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] xid;
    logic [31:0] tup_min;
    logic [31:0] tup_max;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] result_xid;
    logic        visible;
    logic        committed_flag;
    logic [31:0] oldest_active;
    logic [31:0] snap_xmax;
    logic [2:0]  list_count;
    logic        last_item;
  } out_word_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;      // capture the input word, reset the scan
    logic scan;      // examine the slot under the scan pointer
    logic rescan;    // reset the pointer for a second pass
    logic finish;    // apply the op and build the final word
    logic emit_list; // build a snapshot list word from the scanned slot
    logic map_rd;    // apply the commit or abort phase before the second pass
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic       scan_last;
    logic [2:0] op;
    logic       list_hit; // scanned slot qualifies for the snapshot list
    logic       need_oldest; // hit slot is active and holds the oldest id
    logic       clearing; // commit bitmap still being cleared after reset
  } dp_stat_t;

endpackage
`default_nettype wire

@@ sv/mvcc_dp.sv @@
// Datapath of the MVCC transaction table: slot registers, counters, commit bitmap.
// Depends on mvcc_pkg.
`default_nettype none
module mvcc_dp #(
  parameter int unsigned SLOTS   = 8,
  parameter int unsigned MAP_IDS = 1024
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  mvcc_pkg::in_word_t  in_word_i,
  input  mvcc_pkg::dp_cmd_t   cmd_i,
  output mvcc_pkg::dp_stat_t  stat_o,
  output mvcc_pkg::out_word_t out_word_o
);
  localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned MW = $clog2(MAP_IDS);

  logic [31:0] slot_id_q   [SLOTS];
  logic [1:0]  slot_ph_q   [SLOTS];
  logic [31:0] slot_snap_q [SLOTS];
  logic [31:0] next_id_q, oldest_q;

  // Commit bitmap: one read and one write a cycle, read data registered.
  logic          map_mem [MAP_IDS];
  logic          map_rd_q;   // bit at the address presented in the previous cycle
  logic          map_rng_q;  // that address was below MAP_IDS
  logic          clr_busy_q;
  logic [MW-1:0] clr_addr_q;
  logic          map_we;
  logic [MW-1:0] map_wa;
  logic          map_wd;

  mvcc_pkg::in_word_t req_q;
  logic [SW-1:0] ptr_q;
  logic          pass2_q;
  // First-pass results.
  logic          hit_q;      // first matching / free slot found
  logic [SW-1:0] hit_idx_q;
  logic          tmax_hit_q;
  logic [SW-1:0] tmax_idx_q;
  logic          best_vld_q;
  logic [31:0]   best_q;
  logic [31:0]   xmin_q;
  logic [2:0]    cnt_q;
  mvcc_pkg::out_word_t out_q, out_d;

  wire [31:0] cur_id = slot_id_q[ptr_q];
  wire [1:0]  cur_ph = slot_ph_q[ptr_q];
  // A snapshot reads the bit of the scanned id; every other op reads the bit of xid.
  wire [31:0] rd_x = (req_q.op == mvcc_pkg::OP_SNAP) ? cur_id : req_q.xid;
  wire        rd_bit = map_rd_q && map_rng_q;

  wire list_ok = (cur_id != 32'd0) && (cur_id != req_q.xid) && !rd_bit;
  wire cmt_ok  = hit_q && (slot_ph_q[hit_idx_q] == mvcc_pkg::PH_ACTIVE || pass2_q);
  wire [31:0] new_oldest = best_vld_q ? best_q : next_id_q;

  assign stat_o.scan_last = (ptr_q == SW'(SLOTS - 1));
  assign stat_o.op        = req_q.op;
  assign stat_o.list_hit  = list_ok && (cnt_q < 3'(mvcc_pkg::MAX_LIST));
  assign stat_o.need_oldest = hit_q && slot_ph_q[hit_idx_q] == mvcc_pkg::PH_ACTIVE
                              && req_q.xid == oldest_q && req_q.xid != 32'd0;
  assign stat_o.clearing  = clr_busy_q;
  assign out_word_o       = out_q;

  // Scan-step match condition for the first slot found.
  logic cond;
  always_comb begin
    case (req_q.op)
      mvcc_pkg::OP_START:
        cond = (cur_ph == mvcc_pkg::PH_FREE) || (cur_id == 32'd0);
      mvcc_pkg::OP_COMMIT, mvcc_pkg::OP_ABORT:
        cond = (req_q.xid != 32'd0) && (cur_id == req_q.xid);
      default:
        cond = (cur_id == req_q.xid);
    endcase
  end

  // Visibility evaluated from the first-pass results.
  logic        vis;
  logic [31:0] me, snap;
  always_comb begin
    me   = req_q.xid;
    snap = slot_snap_q[hit_idx_q];
    vis  = 1'b0;
    if (req_q.tup_min == me) begin
      vis = (req_q.tup_max == me) || (req_q.tup_max == 32'd0);
    end else if (req_q.tup_min != 32'd0 && req_q.tup_min < snap) begin
      if (req_q.tup_max == 32'd0 || req_q.tup_max > me) vis = 1'b1;
      else if (tmax_hit_q)
        vis = slot_ph_q[tmax_idx_q] != mvcc_pkg::PH_COMMITTED;
    end
  end

  logic [31:0] nid, nid_next;
  always_comb begin
    nid      = next_id_q;
    nid_next = next_id_q + 32'd1;
    if (next_id_q == 32'd0) begin
      nid      = 32'd1;
      nid_next = 32'd2;
    end
  end

  // The clearing pass owns the write port until it is done; no op runs meanwhile.
  always_comb begin
    map_we = 1'b0;
    map_wa = req_q.xid[MW-1:0];
    map_wd = (req_q.op == mvcc_pkg::OP_COMMIT);
    if (clr_busy_q) begin
      map_we = 1'b1;
      map_wa = clr_addr_q;
      map_wd = 1'b0;
    end else if (cmd_i.finish && cmt_ok && req_q.xid < MAP_IDS &&
                 (req_q.op == mvcc_pkg::OP_COMMIT || req_q.op == mvcc_pkg::OP_ABORT)) begin
      map_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (map_we) map_mem[map_wa] <= map_wd;
    map_rd_q <= map_mem[rd_x[MW-1:0]];
  end

  always_comb begin
    out_d = out_q;
    if (cmd_i.scan && cmd_i.emit_list && !pass2_q) begin
      out_d = '0;
      out_d.result_xid    = cur_id;
      out_d.oldest_active = oldest_q;
    end
    if (cmd_i.finish) begin
      out_d = '0;
      out_d.last_item     = 1'b1;
      out_d.oldest_active = oldest_q;
      case (req_q.op)
        mvcc_pkg::OP_START: begin
          if (!hit_q) begin
            out_d.status = mvcc_pkg::ST_NO_SLOT;
          end else begin
            out_d.result_xid = nid;
            if (oldest_q == 32'd0 || oldest_q > nid) out_d.oldest_active = nid;
          end
        end
        mvcc_pkg::OP_COMMIT, mvcc_pkg::OP_ABORT: begin
          if (!hit_q) out_d.status = mvcc_pkg::ST_NOTFOUND;
          else if (!cmt_ok) out_d.status = mvcc_pkg::ST_INACTIVE;
          else if (pass2_q) out_d.oldest_active = new_oldest;
        end
        mvcc_pkg::OP_VISIBLE: begin
          if (!hit_q) out_d.status = mvcc_pkg::ST_NOTFOUND;
          else if (slot_ph_q[hit_idx_q] != mvcc_pkg::PH_ACTIVE)
            out_d.status = mvcc_pkg::ST_INACTIVE;
          else out_d.visible = vis;
        end
        mvcc_pkg::OP_CMTQ:
          out_d.committed_flag = rd_bit;
        mvcc_pkg::OP_SNAP: begin
          out_d.result_xid = xmin_q;
          out_d.snap_xmax  = next_id_q;
          out_d.list_count = cnt_q;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_id_q[i]   <= '0;
        slot_ph_q[i]   <= mvcc_pkg::PH_FREE;
        slot_snap_q[i] <= '0;
      end
      next_id_q <= 32'd1;
      oldest_q  <= 32'd1;
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
      map_rng_q <= 1'b0;
      ptr_q     <= '0;
      pass2_q   <= 1'b0;
      hit_q     <= 1'b0;
      hit_idx_q <= '0;
      tmax_hit_q <= 1'b0;
      tmax_idx_q <= '0;
      best_vld_q <= 1'b0;
      best_q    <= '0;
      xmin_q    <= '0;
      cnt_q     <= '0;
      req_q     <= '0;
      out_q     <= '0;
    end else begin
      out_q     <= out_d;
      map_rng_q <= (rd_x < MAP_IDS);
      if (clr_busy_q) begin
        if (clr_addr_q == MW'(MAP_IDS - 1)) clr_busy_q <= 1'b0;
        else clr_addr_q <= clr_addr_q + MW'(1);
      end
      if (cmd_i.load) begin
        req_q      <= in_word_i;
        ptr_q      <= '0;
        pass2_q    <= 1'b0;
        hit_q      <= 1'b0;
        tmax_hit_q <= 1'b0;
        best_vld_q <= 1'b0;
        xmin_q     <= in_word_i.xid;
        cnt_q      <= '0;
      end
      if (cmd_i.rescan) begin
        ptr_q   <= '0;
        pass2_q <= 1'b1;
      end
      if (cmd_i.scan) begin
        if (!stat_o.scan_last) ptr_q <= ptr_q + SW'(1);
        if (!pass2_q) begin
          if (cond && !hit_q) begin
            hit_q     <= 1'b1;
            hit_idx_q <= ptr_q;
          end
          if (req_q.tup_max != 32'd0 && cur_id == req_q.tup_max && !tmax_hit_q) begin
            tmax_hit_q <= 1'b1;
            tmax_idx_q <= ptr_q;
          end
          if (list_ok && cur_id < xmin_q) xmin_q <= cur_id;
          if (cmd_i.emit_list) cnt_q <= cnt_q + 3'd1;
        end else begin
          // Second pass: oldest active id after the phase change.
          if (cur_ph == mvcc_pkg::PH_ACTIVE && (!best_vld_q || cur_id < best_q)) begin
            best_vld_q <= 1'b1;
            best_q     <= cur_id;
          end
        end
      end
      if (cmd_i.map_rd && stat_o.need_oldest) begin
        // Entering second pass: apply the phase change first.
        if (req_q.op == mvcc_pkg::OP_COMMIT)
          slot_ph_q[hit_idx_q] <= mvcc_pkg::PH_COMMITTED;
        else
          slot_ph_q[hit_idx_q] <= mvcc_pkg::PH_ABORTED;
      end
      if (cmd_i.finish) begin
        case (req_q.op)
          mvcc_pkg::OP_START: begin
            if (hit_q) begin
              slot_id_q[hit_idx_q]   <= nid;
              slot_ph_q[hit_idx_q]   <= mvcc_pkg::PH_ACTIVE;
              slot_snap_q[hit_idx_q] <= oldest_q;
              next_id_q <= nid_next;
              if (oldest_q == 32'd0 || oldest_q > nid) oldest_q <= nid;
            end
          end
          mvcc_pkg::OP_COMMIT, mvcc_pkg::OP_ABORT: begin
            if (cmt_ok) begin
              if (pass2_q) oldest_q <= new_oldest;
              if (req_q.op == mvcc_pkg::OP_COMMIT) begin
                slot_id_q[hit_idx_q] <= '0;
                slot_ph_q[hit_idx_q] <= mvcc_pkg::PH_FREE;
              end else begin
                slot_ph_q[hit_idx_q] <= mvcc_pkg::PH_ABORTED;
              end
            end
          end
          default: ;
        endcase
      end
    end
  end
endmodule
`default_nettype wire

@@ sv/mvcc_ctrl.sv @@
// Controller of the MVCC transaction table: scan sequencing and output handshake.
// Depends on mvcc_pkg.
`default_nettype none
module mvcc_ctrl (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  wire                out_stall_i,
  input  mvcc_pkg::dp_stat_t stat_i,
  output mvcc_pkg::dp_cmd_t  cmd_o
);
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_LIST  = 3'd2;
  localparam logic [2:0] S_SCAN2 = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;
  localparam logic [2:0] S_PRIME = 3'd6;

  logic [2:0] state_q, state_d;
  logic       valid_q, valid_d;

  assign in_stall_o  = (state_q != S_IDLE) || stat_i.clearing;
  assign out_valid_o = valid_q;

  always_comb begin
    state_d = state_q;
    valid_d = valid_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: if (in_valid_i && !stat_i.clearing) begin
        cmd_o.load = 1'b1;
        state_d    = S_PRIME;
      end
      // The bitmap read of the slot under the pointer is registered and lands in S_SCAN.
      S_PRIME: begin
        if (valid_q && !out_stall_i) valid_d = 1'b0;
        state_d = S_SCAN;
      end
      S_SCAN: begin
        if (stat_i.op == mvcc_pkg::OP_SNAP && stat_i.list_hit) begin
          // Wait until the previous list word has been taken.
          if (!valid_q || !out_stall_i) begin
            cmd_o.scan      = 1'b1;
            cmd_o.emit_list = 1'b1;
            valid_d = 1'b1;
            state_d = stat_i.scan_last ? S_LIST : S_PRIME;
          end
        end else begin
          cmd_o.scan = 1'b1;
          if (valid_q && !out_stall_i) valid_d = 1'b0;
          if (stat_i.scan_last) state_d = S_LIST;
          else if (stat_i.op == mvcc_pkg::OP_SNAP) state_d = S_PRIME;
        end
      end
      S_LIST: begin
        if (valid_q && !out_stall_i) valid_d = 1'b0;
        if (stat_i.need_oldest &&
            (stat_i.op == mvcc_pkg::OP_COMMIT || stat_i.op == mvcc_pkg::OP_ABORT)) begin
          cmd_o.map_rd = 1'b1;
          cmd_o.rescan = 1'b1;
          state_d = S_SCAN2;
        end else state_d = S_FIN;
      end
      S_SCAN2: begin
        if (valid_q && !out_stall_i) valid_d = 1'b0;
        cmd_o.scan = 1'b1;
        if (stat_i.scan_last) state_d = S_FIN;
      end
      S_FIN: begin
        if (!valid_q || !out_stall_i) begin
          cmd_o.finish = 1'b1;
          valid_d = 1'b1;
          state_d = S_OUT;
        end
      end
      S_OUT: if (!out_stall_i) begin
        valid_d = 1'b0;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end
endmodule
`default_nettype wire

@@ sv/mvcc_transaction_table.sv @@
// Top level of the MVCC transaction table; joins controller and datapath.
// Depends on mvcc_pkg, mvcc_ctrl and mvcc_dp.
`default_nettype none
// One word is taken at a time. After reset the block clears its commit bitmap
// memory, all MAP_IDS entries, one entry a cycle, and stalls its input until that
// is done. Each op then waits in S_PRIME for the registered bitmap read and, but
// for a snapshot, scans the SLOTS slot registers one slot a cycle. A commit or
// abort of the oldest active id scans a second time to find the new oldest id.
// A snapshot does a bitmap read in S_PRIME before each slot, emits one list word
// per listed id as the scan passes it and holds the scan at a listed id while
// the previous list word is stalled at the output.
module mvcc_transaction_table #(
  parameter int unsigned SLOTS   = 8,
  parameter int unsigned MAP_IDS = 1024
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  mvcc_pkg::in_word_t  in_data_i,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output mvcc_pkg::out_word_t out_data_o
);
  mvcc_pkg::dp_cmd_t  cmd;
  mvcc_pkg::dp_stat_t stat;

  mvcc_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .stat_i(stat), .cmd_o(cmd)
  );

  mvcc_dp #(.SLOTS(SLOTS), .MAP_IDS(MAP_IDS)) u_dp (
    .clk_i, .rst_ni, .in_word_i(in_data_i), .cmd_i(cmd), .stat_o(stat),
    .out_word_o(out_data_o)
  );
endmodule
`default_nettype wire
